// File: hdl/rorq_pkg.sv
package rorq_pkg;

  localparam int DEF_DEPTH      = 16;
  localparam int DEF_READERS    = 4;
  localparam int DEF_WORD_WIDTH = 32;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 2;
  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SIZE  = 2'd3
  } cmd_t;

  // Result flags for one beat, held beside the memory read data.
  typedef struct packed {
    logic              read_valid;
    logic [SIZE_W-1:0] queue_size;
    logic              queue_empty;
  } status_t;

endpackage

// File: hdl/rorq_if.sv
interface rorq_req_if;
  logic                          valid;
  logic                          ready;
  rorq_pkg::cmd_t                command;
  logic [rorq_pkg::INDEX_W-1:0]  reader_index;
  logic [rorq_pkg::DATA_W-1:0]   data_word;

  modport source (output valid, command, reader_index, data_word, input ready);
  modport sink   (input valid, command, reader_index, data_word, output ready);
endinterface

interface rorq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rorq_pkg::DATA_W-1:0]   read_word;
  logic                          read_valid;
  logic [rorq_pkg::SIZE_W-1:0]   queue_size;
  logic                          queue_empty;

  modport source (output valid, read_word, read_valid, queue_size, queue_empty,
                  input ready);
  modport sink   (input valid, read_word, read_valid, queue_size, queue_empty,
                  output ready);
endinterface

// File: hdl/rorq_mem.sv
module rorq_mem #(
  parameter int DEPTH      = rorq_pkg::DEF_DEPTH,
  parameter int WORD_WIDTH = rorq_pkg::DEF_WORD_WIDTH,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [WORD_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [WORD_WIDTH-1:0] rd_data
);

  logic [WORD_WIDTH-1:0] slots [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
  end

  // Hold read data while the result waits downstream.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= slots[rd_addr];
    end
  end

endmodule

// File: hdl/rorq_ptr.sv
module rorq_ptr #(
  parameter int DEPTH   = rorq_pkg::DEF_DEPTH,
  parameter int READERS = rorq_pkg::DEF_READERS,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  rorq_pkg::cmd_t               command,
  input  logic [rorq_pkg::INDEX_W-1:0] reader_index,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [AW-1:0]                rd_addr,
  output rorq_pkg::status_t            status
);
  import rorq_pkg::*;

  localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int SW = (AW > SIZE_W) ? AW : SIZE_W;

  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic [AW-1:0] rp      [READERS];
  logic [AW-1:0] rp_next [READERS];

  logic          have;
  logic [RW-1:0] ridx;
  logic [AW-1:0] rp_sel;
  logic [AW-1:0] rp_sel_next;
  logic          read_ok;
  logic [AW-1:0] count;
  logic [SW-1:0] count_wide;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] ring_count(input logic [AW-1:0] w,
                                               input logic [AW-1:0] r);
    logic [AW:0] d;
    if (w >= r) begin
      d = {1'b0, w} - {1'b0, r};
    end else begin
      d = {1'b0, w} + (AW+1)'(DEPTH) - {1'b0, r};
    end
    return d[AW-1:0];
  endfunction

  assign have    = 32'(reader_index) < READERS;
  assign ridx    = RW'(reader_index);
  assign rp_sel  = have ? rp[ridx] : '0;
  assign read_ok = have && (rp_sel != wp);

  assign wr_en   = accept && (command == CMD_WRITE);
  assign wr_addr = wp;
  assign rd_addr = rp_sel;

  assign wp_next = (command == CMD_WRITE) ? ring_inc(wp) : wp;

  always_comb begin
    for (int k = 0; k < READERS; k++) begin
      rp_next[k] = rp[k];
      case (command)
        CMD_WRITE: begin
          // Drop the oldest word of a reader the writer catches up to.
          if (rp[k] == wp_next) begin
            rp_next[k] = ring_inc(rp[k]);
          end
        end
        CMD_READ: begin
          if (read_ok && (RW'(k) == ridx)) begin
            rp_next[k] = ring_inc(rp[k]);
          end
        end
        CMD_CLEAR: begin
          if (have && (RW'(k) == ridx)) begin
            rp_next[k] = wp;
          end
        end
        default: begin
          rp_next[k] = rp[k];
        end
      endcase
    end
  end

  assign rp_sel_next = have ? rp_next[ridx] : '0;
  assign count       = have ? ring_count(wp_next, rp_sel_next) : '0;
  assign count_wide  = SW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      for (int k = 0; k < READERS; k++) begin
        rp[k] <= '0;
      end
    end else if (accept) begin
      wp <= wp_next;
      for (int k = 0; k < READERS; k++) begin
        rp[k] <= rp_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status.read_valid  <= (command == CMD_READ) && read_ok;
      status.queue_size  <= count_wide[SIZE_W-1:0];
      status.queue_empty <= (count == '0);
    end
  end

endmodule

// File: hdl/replicated_overwrite_ring_queue.sv
// Latency: a result beat appears the cycle after its request beat is taken.
// Throughput: one request per cycle; the request side stalls only while a
// result is held by a stalled response side.
// Reset (rst, synchronous): clears the write pointer, all reader pointers and
// the response valid. Slot contents stay undefined; no clearing pass is run.
module replicated_overwrite_ring_queue #(
  parameter int DEPTH      = rorq_pkg::DEF_DEPTH,
  parameter int READERS    = rorq_pkg::DEF_READERS,
  parameter int WORD_WIDTH = rorq_pkg::DEF_WORD_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  rorq_req_if.sink   req,
  rorq_rsp_if.source rsp
);
  import rorq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  accept;
  logic                  out_valid;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;
  status_t               status;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  rorq_ptr #(
    .DEPTH   (DEPTH),
    .READERS (READERS)
  ) u_ptr (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (req.command),
    .reader_index (req.reader_index),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .status       (status)
  );

  rorq_mem #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (WORD_WIDTH'(req.data_word)),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_word   = status.read_valid ? DATA_W'(rd_data) : '0;
  assign rsp.read_valid  = status.read_valid;
  assign rsp.queue_size  = status.queue_size;
  assign rsp.queue_empty = status.queue_empty;

endmodule

// File: dv/rorq_checker.sv
`timescale 1ns / 1ps

module rorq_checker #(
  parameter int DEPTH      = rorq_pkg::DEF_DEPTH,
  parameter int READERS    = rorq_pkg::DEF_READERS,
  parameter int WORD_WIDTH = rorq_pkg::DEF_WORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  rorq_req_if  req,
  rorq_rsp_if  rsp,
  output int   fail_count,
  output int   outstanding,
  output int   results_checked,
  output int   words_read
);
  import rorq_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_word;
    logic              read_valid;
    logic [SIZE_W-1:0] queue_size;
    logic              queue_empty;
  } ring_result_t;

  localparam logic [63:0] WORD_MASK =
    (WORD_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << WORD_WIDTH) - 64'd1);

  logic [DATA_W-1:0] slot_copy [DEPTH];
  int                write_slot;
  int                read_slot [READERS];
  ring_result_t      awaited_results [$];
  int                mismatches = 0;
  int                checked    = 0;
  int                hits       = 0;

  initial begin
    fail_count      = 0;
    outstanding     = 0;
    results_checked = 0;
    words_read      = 0;
  end

  function automatic int words_held(int r);
    return (write_slot + DEPTH - read_slot[r]) % DEPTH;
  endfunction

  // Apply one request to the shadow ring and return the beat it should produce.
  function automatic ring_result_t ring_apply(cmd_t cmd, logic [INDEX_W-1:0] idx,
                                              logic [DATA_W-1:0] data);
    ring_result_t res;
    int           r;
    int           held;
    bit           present;
    res     = '0;
    r       = int'(idx);
    present = r < READERS;
    case (cmd)
      CMD_WRITE: begin
        slot_copy[write_slot] = DATA_W'(64'(data) & WORD_MASK);
        write_slot = (write_slot + 1) % DEPTH;
        // drop the oldest word of any reader the writer has caught up with
        for (int k = 0; k < READERS; k++)
          if (read_slot[k] == write_slot) read_slot[k] = (read_slot[k] + 1) % DEPTH;
      end
      CMD_READ: begin
        if (present) begin
          if (read_slot[r] != write_slot) begin
            res.read_word  = slot_copy[read_slot[r]];
            res.read_valid = 1'b1;
            read_slot[r]   = (read_slot[r] + 1) % DEPTH;
          end
        end
      end
      CMD_CLEAR: begin
        if (present) read_slot[r] = write_slot;
      end
      default: ;
    endcase
    held            = present ? words_held(r) : 0;
    res.queue_size  = SIZE_W'(held);
    res.queue_empty = (held == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    ring_result_t want;
    if (rst) begin
      write_slot = 0;
      for (int k = 0; k < READERS; k++) read_slot[k] = 0;
      awaited_results.delete();
    end else begin
      // a result beat always belongs to a request taken at an earlier edge
      if (rsp.valid && rsp.ready) begin
        checked++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result beat: word %h valid %b size %0d empty %b",
                     $realtime, rsp.read_word, rsp.read_valid, rsp.queue_size,
                     rsp.queue_empty);
        end else begin
          want = awaited_results.pop_front();
          if (want.read_valid) hits++;
          if (rsp.read_word !== want.read_word || rsp.read_valid !== want.read_valid ||
              rsp.queue_size !== want.queue_size || rsp.queue_empty !== want.queue_empty)
          begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d mismatch: expected word %h valid %b size %0d empty %b",
                       $realtime, checked, want.read_word, want.read_valid,
                       want.queue_size, want.queue_empty);
              $display("    got word %h valid %b size %0d empty %b",
                       rsp.read_word, rsp.read_valid, rsp.queue_size, rsp.queue_empty);
            end
          end
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(ring_apply(req.command, req.reader_index, req.data_word));
    end
    fail_count      <= mismatches;
    outstanding     <= awaited_results.size();
    results_checked <= checked;
    words_read      <= hits;
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rorq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int SEGMENT      = 50;

  logic clk = 1'b0;
  logic rst;
  bit   no_idle = 1'b0;
  int   requests_sent = 0;
  int   cycle_count = 0;
  int   fail_count, outstanding, results_checked, words_read;

  rorq_req_if req_ch ();
  rorq_rsp_if rsp_ch ();

  replicated_overwrite_ring_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  rorq_checker ring_check (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .words_read      (words_read)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one request beat; returns at the edge where it is taken, valid still high.
  task automatic issue(cmd_t cmd, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.reader_index <= idx;
    req_ch.data_word    <= data;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic cmd_t pick_command(int write_pct);
    int roll;
    if ($urandom_range(0, 99) < write_pct) return CMD_WRITE;
    roll = $urandom_range(0, 99);
    if (roll < 55) return CMD_READ;
    if (roll < 70) return CMD_CLEAR;
    return CMD_SIZE;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return {DATA_W/2{2'b01}};
      default: return $urandom;
    endcase
  endfunction

  // Response side: draw a stall before every beat.
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    int write_pct;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.command      <= CMD_WRITE;
    req_ch.reader_index <= '0;
    req_ch.data_word    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty reader, size and clear on an empty ring
    issue(CMD_READ, 2'd0, 32'h0);
    issue(CMD_SIZE, 2'd3, 32'hFFFF_FFFF);
    issue(CMD_CLEAR, 2'd1, 32'h0);
    // fill past capacity so the oldest words get overwritten
    issue(CMD_WRITE, 2'd0, 32'h0000_0000);
    issue(CMD_WRITE, 2'd3, 32'hFFFF_FFFF);
    issue(CMD_WRITE, 2'd1, 32'h5555_5555);
    issue(CMD_WRITE, 2'd2, 32'hAAAA_AAAA);
    for (int i = 0; i < 13; i++)
      issue(CMD_WRITE, INDEX_W'(i), (i % 2) ? ~(32'h1 << (i * 2)) : (32'h1 << (i * 2 + 1)));
    issue(CMD_READ, 2'd0, 32'hFFFF_FFFF);
    issue(CMD_CLEAR, 2'd2, 32'h1234_5678);
    issue(CMD_READ, 2'd2, 32'h0);
    issue(CMD_SIZE, 2'd3, 32'h0);
    issue(CMD_SIZE, 2'd2, 32'h0);
    hold_until_drained();

    // each segment picks filling, draining or mixed traffic at random
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT == 0) begin
        case ($urandom_range(0, 2))
          0:       write_pct = 15;
          1:       write_pct = 45;
          default: write_pct = 85;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      issue(pick_command(write_pct), INDEX_W'($urandom_range(0, 3)), pick_word());
    end
    hold_until_drained();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests; compared %0d result beats, %0d of them returned words",
             requests_sent, results_checked, words_read);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: replicated_overwrite_ring_queue.f
hdl/rorq_pkg.sv
hdl/rorq_if.sv
hdl/rorq_mem.sv
hdl/rorq_ptr.sv
hdl/replicated_overwrite_ring_queue.sv
dv/rorq_checker.sv
dv/tb_top.sv
